// File: hw/rtl/khtc_pkg.sv
// ----------------------------------------------------------------------------
// khtc_pkg
// Shared widths, codes and word types for the key hold/tap classifier.
// ----------------------------------------------------------------------------
package khtc_pkg;

  localparam int unsigned NumKeysDef   = 64;
  localparam int unsigned CountBitsDef = 16;
  localparam int unsigned QueueDepth   = 2;

  localparam int unsigned KeyW    = 6;
  localparam int unsigned ActW    = 2;
  localparam int unsigned TimeW   = 48;
  localparam int unsigned WinW    = 32;
  localparam int unsigned CfgW    = 64;
  localparam int unsigned CntOutW = 16;
  localparam int unsigned KindW   = 2;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [ActW-1:0] ACT_DOWN  = 2'd0;
  localparam logic [ActW-1:0] ACT_UP    = 2'd1;
  localparam logic [ActW-1:0] ACT_OTHER = 2'd2;

  localparam logic [KindW-1:0] KIND_NONE = 2'd0;
  localparam logic [KindW-1:0] KIND_HOLD = 2'd1;
  localparam logic [KindW-1:0] KIND_TAP  = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_WINDOW   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_OVERRIDE = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_POL_LO   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_POL_HI   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MODIFIER = 3'd4;

  localparam logic [WinW-1:0] WindowRst = 32'd500;

  typedef enum logic [1:0] {
    POL_COUNT  = 2'd0,
    POL_ALLOW  = 2'd1,
    POL_IGNORE = 2'd2
  } policy_e;

  typedef struct packed {
    logic [CfgW-1:0] override_mask;
    logic [CfgW-1:0] pol_lo;
    logic [CfgW-1:0] pol_hi;
    logic [CfgW-1:0] modifier_mask;
  } policy_cfg_t;

  // classified event word, front to back
  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [ActW-1:0]  act;
    logic [TimeW-1:0] tstamp;
    logic             in_range;
    policy_e          pol;
  } event_t;

  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [ActW-1:0]    act;
    logic [TimeW-1:0]   tstamp;
    logic [CntOutW-1:0] count;
    logic [KindW-1:0]   kind;
  } result_t;

endpackage

// File: hw/rtl/khtc_fifo.sv
// ----------------------------------------------------------------------------
// khtc_fifo
// Small register queue, one push (while not full) and one pop (while not empty) per cycle.
// ----------------------------------------------------------------------------
module khtc_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = khtc_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: hw/rtl/khtc_front.sv
// ----------------------------------------------------------------------------
// khtc_front
// Accepts key events, resolves key policy and action code, queues the word.
// ----------------------------------------------------------------------------
module khtc_front #(
  parameter int unsigned NumKeys = khtc_pkg::NumKeysDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [khtc_pkg::KeyW-1:0]    key_code_i,
  input  logic [khtc_pkg::ActW-1:0]    action_i,
  input  logic [khtc_pkg::TimeW-1:0]   time_ms_i,
  input  khtc_pkg::policy_cfg_t        cfg_i,
  input  logic                         q_pop_i,
  output logic                         q_empty_o,
  output khtc_pkg::event_t             q_item_o
);

  localparam logic [khtc_pkg::KeyW:0] NumKeysW = (khtc_pkg::KeyW + 1)'(NumKeys);

  logic [1:0]       pol_code;
  logic [5:0]       pol_bit;
  khtc_pkg::event_t ev;

  always_comb begin
    pol_bit  = {key_code_i[4:0], 1'b0};
    pol_code = key_code_i[5] ? cfg_i.pol_hi[pol_bit +: 2] : cfg_i.pol_lo[pol_bit +: 2];

    ev.key      = key_code_i;
    ev.tstamp   = time_ms_i;
    ev.in_range = ({1'b0, key_code_i} < NumKeysW);
    // unknown action code travels as "other"
    ev.act = (action_i == khtc_pkg::ACT_DOWN || action_i == khtc_pkg::ACT_UP) ?
             action_i : khtc_pkg::ACT_OTHER;

    if (cfg_i.override_mask[key_code_i]) begin
      case (pol_code)
        2'(khtc_pkg::POL_ALLOW):  ev.pol = khtc_pkg::POL_ALLOW;
        2'(khtc_pkg::POL_IGNORE): ev.pol = khtc_pkg::POL_IGNORE;
        default:                  ev.pol = khtc_pkg::POL_COUNT;
      endcase
    end else if (cfg_i.modifier_mask[key_code_i]) begin
      ev.pol = khtc_pkg::POL_IGNORE;
    end else begin
      ev.pol = khtc_pkg::POL_COUNT;
    end
  end

  khtc_fifo #(
    .Width ($bits(khtc_pkg::event_t)),
    .Depth (khtc_pkg::QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (ev),
    .full_o  (full),
    .pop_i   (q_pop_i),
    .data_o  (q_item_o),
    .empty_o (q_empty_o)
  );

endmodule

// File: hw/rtl/khtc_back.sv
// ----------------------------------------------------------------------------
// khtc_back
// Per-key state memory: read, update and write back one entry per word.
// ----------------------------------------------------------------------------
module khtc_back #(
  parameter int unsigned NumKeys   = khtc_pkg::NumKeysDef,
  parameter int unsigned CountBits = khtc_pkg::CountBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [khtc_pkg::WinW-1:0]   window_i,
  input  logic                        q_empty_i,
  input  khtc_pkg::event_t            q_item_i,
  output logic                        q_pop_o,
  input  logic                        res_pop_i,
  output logic                        res_empty_o,
  output khtc_pkg::result_t           res_o
);

  localparam int unsigned AddrW = $clog2(NumKeys);
  localparam int unsigned TimeW = khtc_pkg::TimeW;
  localparam logic [CountBits-1:0] CntMax = {CountBits{1'b1}};
  localparam logic [CountBits-1:0] CntOne = CountBits'(1);
  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  typedef struct packed {
    logic                 held;
    logic                 rel_seen;
    logic [TimeW-1:0]     press_time;
    logic [TimeW-1:0]     rel_time;
    logic [CountBits-1:0] hold_cnt;
    logic [CountBits-1:0] tap_cnt;
  } entry_t;

  function automatic logic [CountBits-1:0] sat_inc(input logic [CountBits-1:0] v);
    return (v == CntMax) ? v : v + 1'b1;
  endfunction

  entry_t             mem_q [NumKeys];
  entry_t             rd_q, cur_e, new_e;
  logic               rd_valid_q;
  logic [NumKeys-1:0] valid_q;
  khtc_pkg::event_t   cur_q;
  logic               state_q, state_d;

  logic               start, exec, we, drop, res_full, res_push;
  logic [AddrW-1:0]   rd_addr, wr_addr;
  logic [TimeW:0]     diff_p, diff_r;
  logic               win_p, win_r;
  logic [CountBits-1:0]      cnt;
  logic [khtc_pkg::KindW-1:0] kind;
  logic [31:0]        cnt32;
  khtc_pkg::result_t  res;

  assign start   = (state_q == StIdle) && !q_empty_i && !res_full;
  assign exec    = (state_q == StExec);
  assign q_pop_o = start;
  assign rd_addr = q_item_i.key[AddrW-1:0];
  assign wr_addr = cur_q.key[AddrW-1:0];
  assign state_d = start ? StExec : StIdle;

  // entries never written read as zero
  assign cur_e  = rd_valid_q ? rd_q : '0;
  assign diff_p = {1'b0, cur_q.tstamp} - {1'b0, cur_e.press_time};
  assign diff_r = {1'b0, cur_q.tstamp} - {1'b0, cur_e.rel_time};
  assign win_p  = !diff_p[TimeW] && (diff_p[TimeW-1:0] <= TimeW'(window_i));
  assign win_r  = !diff_r[TimeW] && (diff_r[TimeW-1:0] <= TimeW'(window_i));

  always_comb begin
    new_e = cur_e;
    we    = 1'b0;
    drop  = 1'b0;
    kind  = khtc_pkg::KIND_NONE;
    cnt   = CntOne;
    if (cur_q.in_range) begin
      case (cur_q.act)
        khtc_pkg::ACT_DOWN: begin
          if (cur_q.pol == khtc_pkg::POL_ALLOW) begin
            new_e.held = 1'b1;
            we         = 1'b1;
          end else if (cur_q.pol == khtc_pkg::POL_IGNORE && cur_e.held) begin
            drop = 1'b1;
          end else begin
            if (cur_e.held && win_p) begin
              new_e.hold_cnt = sat_inc(cur_e.hold_cnt);
              kind           = khtc_pkg::KIND_HOLD;
              cnt            = new_e.hold_cnt;
            end else begin
              new_e.hold_cnt = CntOne;
              new_e.tap_cnt  = (cur_e.rel_seen && win_r) ? sat_inc(cur_e.tap_cnt) : CntOne;
              if (new_e.tap_cnt > CntOne) begin
                kind = khtc_pkg::KIND_TAP;
                cnt  = new_e.tap_cnt;
              end else begin
                cnt = new_e.hold_cnt;
              end
            end
            new_e.press_time = cur_q.tstamp;
            // repeated press under ignore-spam: state moves on, word dropped
            if (cur_q.pol == khtc_pkg::POL_IGNORE && cnt > CntOne) begin
              drop = 1'b1;
            end else begin
              new_e.held = 1'b1;
            end
            we = 1'b1;
          end
        end
        khtc_pkg::ACT_UP: begin
          new_e.held     = 1'b0;
          new_e.rel_time = cur_q.tstamp;
          new_e.rel_seen = 1'b1;
          new_e.hold_cnt = '0;
          we             = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign res_push   = exec && !drop;
  assign cnt32      = 32'(cnt);
  assign res.key    = cur_q.key;
  assign res.act    = cur_q.act;
  assign res.tstamp = cur_q.tstamp;
  assign res.kind   = kind;
  assign res.count  = (cnt32 > 32'h0000_FFFF) ? {khtc_pkg::CntOutW{1'b1}} :
                      cnt32[khtc_pkg::CntOutW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      if (exec && we) begin
        valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      cur_q      <= q_item_i;
      rd_q       <= mem_q[rd_addr];
      rd_valid_q <= valid_q[rd_addr];
    end
    if (exec && we) begin
      mem_q[wr_addr] <= new_e;
    end
  end

  khtc_fifo #(
    .Width ($bits(khtc_pkg::result_t)),
    .Depth (khtc_pkg::QueueDepth)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (res_pop_i),
    .data_o  (res_o),
    .empty_o (res_empty_o)
  );

endmodule

// File: hw/rtl/key_hold_tap_classifier.sv
// ----------------------------------------------------------------------------
// key_hold_tap_classifier
// Classifies key presses as holds or taps and passes events with their count.
// ----------------------------------------------------------------------------
// Input channel: a word (key code, action, time) goes in at an edge with push
// high and full low. A two-word queue sits behind it, so words are taken on
// back-to-back cycles until it fills.
// Result channel: while empty is low the oldest result is on the out ports;
// it leaves at an edge with pop high. Dropped events give no word.
// A taken word passes the input queue, then the entry read into the state
// unit's registers, then the update, which writes the entry back and pushes the result.
// The state unit takes no new event until it has written back the per-key
// state entry of the last one, which it reads and then writes in the state memory.
// Stall: the result queue holds two words; when it is full the state unit
// waits, the input queue fills and full goes high.
// Reset: all keys read as released with zero times and counts (per-key valid
// bits, no clearing pass); window 500 ms, all masks zero. The user must write config
// through cfg_we_i / cfg_index_i / cfg_data_i while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module key_hold_tap_classifier #(
  parameter int unsigned NUM_KEYS   = khtc_pkg::NumKeysDef,
  parameter int unsigned COUNT_BITS = khtc_pkg::CountBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [khtc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [khtc_pkg::CfgW-1:0]       cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  logic [khtc_pkg::KeyW-1:0]       key_code_i,
  input  logic [khtc_pkg::ActW-1:0]       action_i,
  input  logic [khtc_pkg::TimeW-1:0]      time_ms_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [khtc_pkg::KeyW-1:0]       out_key_o,
  output logic [khtc_pkg::ActW-1:0]       out_action_o,
  output logic [khtc_pkg::TimeW-1:0]      out_time_o,
  output logic [khtc_pkg::CntOutW-1:0]    count_out_o,
  output logic [khtc_pkg::KindW-1:0]      out_kind_o
);

  logic [khtc_pkg::WinW-1:0] win_q;
  khtc_pkg::policy_cfg_t     pcfg_q;
  logic                      q_empty, q_pop;
  khtc_pkg::event_t          q_item;
  khtc_pkg::result_t         res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= khtc_pkg::WindowRst;
      pcfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        khtc_pkg::REG_WINDOW: begin
          // zero window is stored as 1 ms
          win_q <= (cfg_data_i[khtc_pkg::WinW-1:0] == '0) ? khtc_pkg::WinW'(1) :
                   cfg_data_i[khtc_pkg::WinW-1:0];
        end
        khtc_pkg::REG_OVERRIDE: pcfg_q.override_mask <= cfg_data_i;
        khtc_pkg::REG_POL_LO:   pcfg_q.pol_lo        <= cfg_data_i;
        khtc_pkg::REG_POL_HI:   pcfg_q.pol_hi        <= cfg_data_i;
        khtc_pkg::REG_MODIFIER: pcfg_q.modifier_mask <= cfg_data_i;
        default: ;
      endcase
    end
  end

  khtc_front #(
    .NumKeys (NUM_KEYS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .key_code_i (key_code_i),
    .action_i   (action_i),
    .time_ms_i  (time_ms_i),
    .cfg_i      (pcfg_q),
    .q_pop_i    (q_pop),
    .q_empty_o  (q_empty),
    .q_item_o   (q_item)
  );

  khtc_back #(
    .NumKeys   (NUM_KEYS),
    .CountBits (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .window_i    (win_q),
    .q_empty_i   (q_empty),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .res_pop_i   (pop),
    .res_empty_o (empty),
    .res_o       (res)
  );

  assign out_key_o    = res.key;
  assign out_action_o = res.act;
  assign out_time_o   = res.tstamp;
  assign count_out_o  = res.count;
  assign out_kind_o   = res.kind;

`ifndef SYNTHESIS
  a_window_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_q != '0) else $error("repeat window register holds zero");

  a_pop_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("state unit took a word from an empty queue");

  a_rmw_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> !q_pop) else $error("state unit took words on consecutive cycles");

  a_full_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !q_empty) else $error("input queue full but holds no word");
`endif

endmodule
